[rtl/pctt_pkg.sv]
// Shared types, command and result codes, and the control-store program
// for the periodic callback timer table. Depends on nothing else.
package pctt_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_UNSET = 2'd2;

  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;

  localparam logic [3:0] MaxResults = 4'd8;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] count;
    logic [7:0]  calls;
  } slot_t;

  typedef enum logic [2:0] {
    PC_IDLE,
    PC_TICK_RD,
    PC_TICK_EV,
    PC_SET_RD,
    PC_SET_EV,
    PC_UNSET,
    PC_FLUSH
  } pc_e;

  typedef enum logic [2:0] {
    ACT_DISPATCH,
    ACT_READ0,
    ACT_TICK,
    ACT_SET,
    ACT_UNSET,
    ACT_FLUSH
  } act_e;

  typedef struct packed {
    logic accept;
    act_e act;
    pc_e  next_pc;
    pc_e  alt_pc;
  } uop_t;

  function automatic uop_t ucode_rom(input pc_e pc);
    uop_t u;
    u = '{accept: 1'b0, act: ACT_FLUSH, next_pc: PC_IDLE, alt_pc: PC_IDLE};
    unique case (pc)
      PC_IDLE:    u = '{accept: 1'b1, act: ACT_DISPATCH, next_pc: PC_IDLE,    alt_pc: PC_IDLE};
      PC_TICK_RD: u = '{accept: 1'b0, act: ACT_READ0,    next_pc: PC_TICK_EV, alt_pc: PC_IDLE};
      PC_TICK_EV: u = '{accept: 1'b0, act: ACT_TICK,     next_pc: PC_TICK_EV, alt_pc: PC_FLUSH};
      PC_SET_RD:  u = '{accept: 1'b0, act: ACT_READ0,    next_pc: PC_SET_EV,  alt_pc: PC_IDLE};
      PC_SET_EV:  u = '{accept: 1'b0, act: ACT_SET,      next_pc: PC_SET_EV,  alt_pc: PC_FLUSH};
      PC_UNSET:   u = '{accept: 1'b0, act: ACT_UNSET,    next_pc: PC_IDLE,    alt_pc: PC_IDLE};
      PC_FLUSH:   u = '{accept: 1'b0, act: ACT_FLUSH,    next_pc: PC_IDLE,    alt_pc: PC_IDLE};
      default:    u = '{accept: 1'b0, act: ACT_FLUSH,    next_pc: PC_IDLE,    alt_pc: PC_IDLE};
    endcase
    return u;
  endfunction

endpackage

[rtl/pctt_cmd_if.sv]
// Command channel of the periodic callback timer table: valid, ready and
// one command word. Depends on nothing else.
interface pctt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] period_ticks;
  logic [7:0]  call_limit;
  logic [2:0]  slot_sel;

  modport source (output valid, output cmd, output period_ticks, output call_limit,
                  output slot_sel, input ready);
  modport sink (input valid, input cmd, input period_ticks, input call_limit,
                input slot_sel, output ready);
endinterface

[rtl/pctt_res_if.sv]
// Result channel of the periodic callback timer table: valid, ready and
// one result word. Depends on nothing else.
interface pctt_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] result_slot;
  logic       last;

  modport source (output valid, output kind, output result_slot, output last, input ready);
  modport sink (input valid, input kind, input result_slot, input last, output ready);
endinterface

[rtl/pctt_slot_mem.sv]
// Slot memory: one write port, one registered read port, and a valid flag
// per entry so that an entry never written since reset reads as zero.
// Depends on pctt_pkg.
module pctt_slot_mem #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   rd_en_i,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0]   rd_addr_i,
  output pctt_pkg::slot_t                                        rd_data_o,
  input  logic                                                   wr_en_i,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0]   wr_addr_i,
  input  pctt_pkg::slot_t                                        wr_data_i
);

  pctt_pkg::slot_t        mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   valid_q;
  pctt_pkg::slot_t        rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

[rtl/periodic_callback_timer_table_core.sv]
// Periodic callback timer table, top level. Depends on pctt_pkg, pctt_cmd_if,
// pctt_res_if and pctt_slot_mem.
// A tick runs accept, first read, one slot per cycle unless stalled, then flush.
// A set walks to a free slot or reports full, then flushes; an unset clears a slot.
// The slot walk through the single-read-port memory sets the rate; a full
// output word that is not taken stalls the walk. After reset every slot is free.
module periodic_callback_timer_table_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pctt_cmd_if.sink    cmd_i,
  pctt_res_if.source  res_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);
  localparam logic [6:0] NumSlotsW = 7'(NUM_SLOTS);

  pctt_pkg::pc_e   pc_q, pc_d;
  pctt_pkg::uop_t  uop;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     period_q, period_d;
  logic [7:0]      limit_q, limit_d;
  logic [2:0]      sel_q, sel_d;
  logic            hold_valid_q, hold_valid_d;
  logic [1:0]      hold_kind_q, hold_kind_d;
  logic [2:0]      hold_slot_q, hold_slot_d;
  logic [3:0]      fires_q, fires_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_kind_q, out_kind_d;
  logic [2:0]      out_slot_q, out_slot_d;
  logic            out_last_q, out_last_d;

  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  pctt_pkg::slot_t rd_data, wr_data, tick_data;
  logic            accept, out_free, active, fire, emit, out_load;

  pctt_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign uop         = pctt_pkg::ucode_rom(pc_q);
  assign cmd_i.ready = uop.accept;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  assign active = rd_data.period != 16'd0;
  assign fire   = active && (rd_data.period == rd_data.count);
  assign emit   = fire && (fires_q < pctt_pkg::MaxResults);

  always_comb begin
    tick_data = rd_data;
    if (fire && rd_data.calls == 8'd1) begin
      tick_data = '0;
    end else if (fire) begin
      tick_data.count = 16'd1;
      tick_data.calls = (rd_data.calls != 8'd0) ? rd_data.calls - 8'd1 : 8'd0;
    end else begin
      tick_data.count = rd_data.count + 16'd1;
    end
  end

  always_comb begin
    pc_d         = pc_q;
    idx_d        = idx_q;
    period_d     = period_q;
    limit_d      = limit_q;
    sel_d        = sel_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_slot_d  = hold_slot_q;
    fires_d      = fires_q;
    out_load     = 1'b0;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q + IdxW'(1);
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = tick_data;

    unique case (uop.act)
      pctt_pkg::ACT_DISPATCH: begin
        if (accept) begin
          period_d     = cmd_i.period_ticks;
          limit_d      = cmd_i.call_limit;
          sel_d        = cmd_i.slot_sel;
          hold_valid_d = 1'b0;
          fires_d      = '0;
          case (cmd_i.cmd)
            pctt_pkg::CMD_TICK:  pc_d = pctt_pkg::PC_TICK_RD;
            pctt_pkg::CMD_SET:   pc_d = pctt_pkg::PC_SET_RD;
            pctt_pkg::CMD_UNSET: pc_d = pctt_pkg::PC_UNSET;
            default:             pc_d = pctt_pkg::PC_IDLE;
          endcase
        end
      end
      pctt_pkg::ACT_READ0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        idx_d   = '0;
        pc_d    = uop.next_pc;
      end
      pctt_pkg::ACT_TICK: begin
        if (!(emit && hold_valid_q && !out_free)) begin
          wr_en = active;
          if (emit) begin
            fires_d      = fires_q + 4'd1;
            out_load     = hold_valid_q;
            out_last_d   = hold_valid_q ? 1'b0 : out_last_q;
            hold_valid_d = 1'b1;
            hold_kind_d  = pctt_pkg::KIND_FIRED;
            hold_slot_d  = 3'(idx_q);
          end
          if (idx_q == LastIdx) begin
            pc_d = uop.alt_pc;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_q + IdxW'(1);
            pc_d  = uop.next_pc;
          end
        end
      end
      pctt_pkg::ACT_SET: begin
        if (!active) begin
          wr_en        = 1'b1;
          wr_data      = '{period: period_q, count: 16'd0, calls: limit_q};
          hold_valid_d = 1'b1;
          hold_kind_d  = pctt_pkg::KIND_ASSIGNED;
          hold_slot_d  = 3'(idx_q);
          pc_d         = uop.alt_pc;
        end else if (idx_q == LastIdx) begin
          hold_valid_d = 1'b1;
          hold_kind_d  = pctt_pkg::KIND_FULL;
          hold_slot_d  = 3'd0;
          pc_d         = uop.alt_pc;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + IdxW'(1);
          pc_d  = uop.next_pc;
        end
      end
      pctt_pkg::ACT_UNSET: begin
        wr_en   = {4'd0, sel_q} < NumSlotsW;
        wr_addr = IdxW'(sel_q);
        wr_data = '0;
        pc_d    = uop.next_pc;
      end
      pctt_pkg::ACT_FLUSH: begin
        if (!hold_valid_q) begin
          pc_d = uop.next_pc;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          pc_d         = uop.next_pc;
        end
      end
      default: begin
        pc_d = pctt_pkg::PC_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !res_o.ready);
    out_kind_d  = out_load ? hold_kind_q : out_kind_q;
    out_slot_d  = out_load ? hold_slot_q : out_slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= pctt_pkg::PC_IDLE;
      idx_q        <= '0;
      period_q     <= '0;
      limit_q      <= '0;
      sel_q        <= '0;
      hold_valid_q <= 1'b0;
      hold_kind_q  <= '0;
      hold_slot_q  <= '0;
      fires_q      <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= '0;
      out_slot_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      idx_q        <= idx_d;
      period_q     <= period_d;
      limit_q      <= limit_d;
      sel_q        <= sel_d;
      hold_valid_q <= hold_valid_d;
      hold_kind_q  <= hold_kind_d;
      hold_slot_q  <= hold_slot_d;
      fires_q      <= fires_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_slot_q   <= out_slot_d;
      out_last_q   <= out_last_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.result_slot = out_slot_q;
  assign res_o.last        = out_last_q;

`ifndef SYNTHESIS
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == pctt_pkg::PC_IDLE |-> !hold_valid_q)
    else $error("pending result left over in idle");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= pctt_pkg::MaxResults)
    else $error("more results than allowed for one tick");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_o.ready))
    else $error("output word overwritten before it was taken");

  a_port_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same slot in one cycle");
`endif

endmodule

[tb/sv/periodic_callback_timer_table_core_test.sv]
// Self-checking testbench for periodic_callback_timer_table_core: directed and random
// tick, set and unset words, with results checked against a timer table model kept here.
// Depends on pctt_pkg, pctt_cmd_if, pctt_res_if and the core itself.
module periodic_callback_timer_table_core_test;

  localparam int NUM_SLOTS = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       last;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  pctt_cmd_if cmd_bus ();
  pctt_res_if res_bus ();

  periodic_callback_timer_table_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  logic [15:0] slot_period [NUM_SLOTS];
  logic [15:0] slot_count [NUM_SLOTS];
  logic [7:0]  slot_calls [NUM_SLOTS];

  reply_t      pending_replies [$];
  int unsigned mismatches = 0;
  bit          steady_flow = 1'b0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void free_slot(input int idx);
    slot_period[idx] = '0;
    slot_count[idx]  = '0;
    slot_calls[idx]  = '0;
  endfunction

  // Updates the table for one accepted word and queues the replies it causes.
  function automatic void apply_command(input logic [1:0] op, input logic [15:0] period,
                                        input logic [7:0] limit, input logic [2:0] sel);
    int     fired [$];
    bit     placed;
    reply_t r;
    placed = 1'b0;
    case (op)
      pctt_pkg::CMD_SET: begin
        for (int idx = 0; idx < NUM_SLOTS && !placed; idx++) begin
          if (slot_period[idx] == '0) begin
            slot_period[idx] = period;
            slot_count[idx]  = '0;
            slot_calls[idx]  = limit;
            r = '{kind: pctt_pkg::KIND_ASSIGNED, slot: idx[2:0], last: 1'b1};
            pending_replies.push_back(r);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          r = '{kind: pctt_pkg::KIND_FULL, slot: 3'd0, last: 1'b1};
          pending_replies.push_back(r);
        end
      end
      pctt_pkg::CMD_UNSET: begin
        if (sel < NUM_SLOTS) free_slot(int'(sel));
      end
      pctt_pkg::CMD_TICK: begin
        for (int idx = 0; idx < NUM_SLOTS; idx++) begin
          if (slot_period[idx] != '0) begin
            if (slot_period[idx] == slot_count[idx]) begin
              if (fired.size() < pctt_pkg::MaxResults) fired.push_back(idx);
              slot_count[idx] = '0;
              if (slot_calls[idx] == 8'd1) begin
                free_slot(idx);
                continue;
              end
              if (slot_calls[idx] != '0) slot_calls[idx] = slot_calls[idx] - 8'd1;
            end
            slot_count[idx] = slot_count[idx] + 16'd1;
          end
        end
        foreach (fired[i]) begin
          r = '{kind: pctt_pkg::KIND_FIRED, slot: fired[i][2:0],
                last: (i == fired.size() - 1)};
          pending_replies.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] period,
                           input logic [7:0] limit, input logic [2:0] sel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.cmd          <= op;
    cmd_bus.period_ticks <= period;
    cmd_bus.call_limit   <= limit;
    cmd_bus.slot_sel     <= sel;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    apply_command(op, period, limit, sel);
  endtask

  // Mostly short periods and small call counts so that slots fire and expire often.
  task automatic send_random_word();
    int          r;
    logic [15:0] period;
    logic [7:0]  limit;
    logic [2:0]  sel;
    r      = $urandom_range(0, 99);
    period = 16'($urandom_range(0, 65535));
    limit  = 8'($urandom_range(0, 255));
    sel    = 3'($urandom_range(0, 7));
    if (r < 50) begin
      send_word(pctt_pkg::CMD_TICK, period, limit, sel);
    end else if (r < 75) begin
      if ($urandom_range(0, 9) < 8) period = 16'($urandom_range(1, 6));
      if ($urandom_range(0, 9) < 6) limit = 8'($urandom_range(0, 3));
      send_word(pctt_pkg::CMD_SET, period, limit, sel);
    end else if (r < 95) begin
      send_word(pctt_pkg::CMD_UNSET, period, limit, sel);
    end else begin
      send_word(CMD_UNUSED, period, limit, sel);
    end
  endtask

  task automatic test_empty_table();
    send_word(pctt_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 3'd7);
    send_word(pctt_pkg::CMD_SET, 16'd0, 8'd0, 3'd0);
    send_word(pctt_pkg::CMD_TICK, 16'd0, 8'd0, 3'd0);
  endtask

  task automatic test_fill_and_full();
    send_word(pctt_pkg::CMD_SET, 16'd1, 8'd1, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'hFFFF, 8'hFF, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd2, 8'd0, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd1, 8'd2, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd3, 8'd128, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd4, 8'd1, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd2, 8'd3, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd5, 8'd0, 3'd0);
    send_word(pctt_pkg::CMD_SET, 16'd7, 8'd7, 3'd7);
  endtask

  task automatic test_fire_and_expire();
    repeat (5) send_word(pctt_pkg::CMD_TICK, 16'd0, 8'd0, 3'd0);
  endtask

  task automatic test_unset_and_ignore();
    send_word(pctt_pkg::CMD_UNSET, 16'd0, 8'd0, 3'd1);
    send_word(pctt_pkg::CMD_UNSET, 16'd0, 8'd0, 3'd0);
    send_word(CMD_UNUSED, 16'hFFFF, 8'hFF, 3'd7);
    send_word(pctt_pkg::CMD_SET, 16'd3, 8'd0, 3'd0);
    repeat (2) send_word(pctt_pkg::CMD_TICK, 16'd0, 8'd0, 3'd0);
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (60) send_random_word();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    repeat (340) send_random_word();
  endtask

  task automatic finish_run();
    cmd_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4 * NUM_SLOTS + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("periodic_callback_timer_table_core_test passed");
    end else begin
      $display("periodic_callback_timer_table_core_test failed");
    end
    $finish;
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.cmd          <= pctt_pkg::CMD_TICK;
    cmd_bus.period_ticks <= '0;
    cmd_bus.call_limit   <= '0;
    cmd_bus.slot_sel     <= '0;
    for (int idx = 0; idx < NUM_SLOTS; idx++) free_slot(idx);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_and_full();
    test_fire_and_expire();
    test_unset_and_ignore();
    test_back_to_back();
    test_random_traffic();
    finish_run();
  end

  initial begin
    int hold;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word: kind %0d, result_slot %0d, last %0d",
               res_bus.kind, res_bus.result_slot, res_bus.last);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (res_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_bus.kind);
          mismatches++;
        end
        if (res_bus.result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, res_bus.result_slot);
          mismatches++;
        end
        if (res_bus.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_bus.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("periodic_callback_timer_table_core_test failed");
    $finish;
  end

endmodule
